@@ design/lgp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgp_pkg
// Shared types, codes and constants of the light-gun port.
// ----------------------------------------------------------------------------
package lgp_pkg;

    // Field widths of the channels
    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 9;
    localparam int CYCLE_W  = 17;
    localparam int COLOR_W  = 6;
    localparam int DATA_W   = 8;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 17;

    // Default screen geometry
    localparam int SCREEN_WIDTH_DEF  = 256;
    localparam int SCREEN_HEIGHT_DEF = 240;

    // Function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_FRAME = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_SERIAL_MODE = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_DECAY       = 1'd1;

    // Reset values
    localparam logic [CYCLE_W-1:0] DECAY_RESET       = 17'd384;
    localparam logic [DATA_W-1:0]  SERIAL_WORD_RESET = 8'h10;

    // Read data bits
    localparam logic [DATA_W-1:0] RD_TRIGGER  = 8'h10;
    localparam logic [DATA_W-1:0] RD_NO_LIGHT = 8'h08;
    localparam logic [DATA_W-1:0] SW_TRIGGER  = 8'h80;
    localparam logic [DATA_W-1:0] SW_LIGHT    = 8'h40;
    localparam logic [DATA_W-1:0] SW_FIXED    = 8'h10;

    // Brightness threshold for a lit pixel
    localparam logic [7:0] BRIGHT_MIN = 8'h40;

    localparam logic [7:0] BRIGHTNESS [0:63] = '{
        8'h66, 8'h1C, 8'h1F, 8'h2A, 8'h31, 8'h2D, 8'h27, 8'h26,
        8'h29, 8'h2E, 8'h34, 8'h32, 8'h30, 8'h00, 8'h00, 8'h00,
        8'hB9, 8'h52, 8'h52, 8'h51, 8'h53, 8'h4F, 8'h54, 8'h59,
        8'h5E, 8'h5A, 8'h5A, 8'h5E, 8'h5D, 8'h00, 8'h00, 8'h00,
        8'hFF, 8'hA4, 8'hA0, 8'hA2, 8'hA2, 8'h9D, 8'hA0, 8'hA6,
        8'hA9, 8'hA8, 8'hA6, 8'hA6, 8'hAB, 8'h60, 8'h00, 8'h00,
        8'hFF, 8'hD8, 8'hD5, 8'hD1, 8'hCE, 8'hCE, 8'hCF, 8'hD5,
        8'hDD, 8'hD5, 8'hD1, 8'hD0, 8'hD6, 8'hBD, 8'h00, 8'h00
    };

    // One input item
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic               sample_valid;
        logic [COORD_W-1:0] gun_x;
        logic [COORD_W-1:0] gun_y;
        logic               trigger;
        logic               write_bit;
        logic [CYCLE_W-1:0] pixel_cycle;
        logic [COLOR_W-1:0] aim_pixel_color;
    } t_item;

    function automatic logic is_bright(input logic [COLOR_W-1:0] color);
        return BRIGHTNESS[color] >= BRIGHT_MIN;
    endfunction

endpackage
`default_nettype wire

@@ design/lgp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgp_if
// Handshake channels of the light-gun port: items, results, configuration.
// ----------------------------------------------------------------------------
interface lgp_item_if;
    logic                         valid;
    logic                         ready;
    logic [lgp_pkg::FUNC_W-1:0]   func;
    logic                         sample_valid;
    logic [lgp_pkg::COORD_W-1:0]  gun_x;
    logic [lgp_pkg::COORD_W-1:0]  gun_y;
    logic                         trigger;
    logic                         write_bit;
    logic [lgp_pkg::CYCLE_W-1:0]  pixel_cycle;
    logic [lgp_pkg::COLOR_W-1:0]  aim_pixel_color;

    modport source (
        output valid, func, sample_valid, gun_x, gun_y, trigger, write_bit,
               pixel_cycle, aim_pixel_color,
        input  ready
    );
    modport sink (
        input  valid, func, sample_valid, gun_x, gun_y, trigger, write_bit,
               pixel_cycle, aim_pixel_color,
        output ready
    );
endinterface

interface lgp_result_if;
    logic                        valid;
    logic                        ready;
    logic [lgp_pkg::DATA_W-1:0]  read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

interface lgp_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lgp_pkg::CFG_A_W-1:0] addr;
    logic [lgp_pkg::CFG_D_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

@@ design/lgp_light_detect.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgp_light_detect
// Decides whether the gun sees light at the current pixel cycle.
// ----------------------------------------------------------------------------
module lgp_light_detect #(
    parameter int POS_W = 16
) (
    input  wire logic [POS_W-1:0]            i_aim_pos,
    input  wire logic                        i_aim_valid,
    input  wire logic [lgp_pkg::CYCLE_W-1:0] i_pixel_cycle,
    input  wire logic [lgp_pkg::COLOR_W-1:0] i_color,
    input  wire logic [lgp_pkg::CYCLE_W-1:0] i_decay_window,
    output logic                             o_light
);
    import lgp_pkg::*;

    localparam int CMP_W = ((POS_W > CYCLE_W) ? POS_W : CYCLE_W) + 1;

    logic [CMP_W-1:0] w_aim;
    logic [CMP_W-1:0] w_cyc;
    logic [CMP_W-1:0] w_age;
    logic             w_drawn;
    logic             w_recent;

    assign w_aim    = CMP_W'(i_aim_pos);
    assign w_cyc    = CMP_W'(i_pixel_cycle);
    assign w_age    = w_cyc - w_aim;
    // Pixel already drawn this frame, no wrap below zero
    assign w_drawn  = w_aim < w_cyc;
    assign w_recent = w_age <= CMP_W'(i_decay_window);

    assign o_light = i_aim_valid && w_drawn && w_recent && is_bright(i_color);

endmodule
`default_nettype wire

@@ design/light_gun_port.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// light_gun_port
// Light-gun controller port: frame latch of aim and trigger, port reads in
// normal parallel or serial shift format.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output side does not stall. An accepted
// item sits in the input register, where its whole effect is computed (aim
// latch, light test, serial shift). A read puts its result in the output
// register as it leaves the input register, so read data passes the input
// register and then the output register. Frame and write items produce no
// result. The only stall comes from the output side: a read held in the input
// register waits while the output register holds an item not yet taken, and
// then the input side stops too. The longest path is the light test: a
// subtract of the aim position from the pixel cycle, a compare against the
// decay window and a 64-entry brightness lookup. Configuration writes are
// always taken and registered; change them only while no item is in flight.
// ----------------------------------------------------------------------------
module light_gun_port #(
    parameter int SCREEN_WIDTH  = lgp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = lgp_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lgp_item_if.sink     i_item,
    lgp_result_if.source o_result,
    lgp_cfg_if.sink      i_cfg
);
    import lgp_pkg::*;

    localparam int SCREEN_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int POS_W         = (SCREEN_PIXELS > 1) ? $clog2(SCREEN_PIXELS) : 1;
    localparam int BOUND_W       = COORD_W + 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(SCREEN_PIXELS - 1);

    // Configuration
    logic               r_serial_mode;
    logic [CYCLE_W-1:0] r_decay_window;

    // Port state
    logic [POS_W-1:0]   r_aim_pos,      n_aim_pos;
    logic               r_aim_valid,    n_aim_valid;
    logic               r_trigger_held, n_trigger_held;
    logic               r_shift_en,     n_shift_en;
    logic [DATA_W-1:0]  r_serial_word,  n_serial_word;

    // Input register
    t_item              r_s1;
    logic               r_s1_valid;

    // Output register
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_data,     n_out_data;

    logic               w_s1_is_read;
    logic               w_out_free;
    logic               w_s1_adv;
    logic               w_on_screen;
    logic               w_light;

    // ------------------------------------------------------------------
    // Configuration port: always ready
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial_mode  <= 1'b0;
            r_decay_window <= DECAY_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                CFG_SERIAL_MODE: r_serial_mode  <= i_cfg.data[0];
                CFG_DECAY:       r_decay_window <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: only a read needs room in the output register
    // ------------------------------------------------------------------
    assign w_s1_is_read  = r_s1.func == FUNC_READ;
    assign w_out_free    = !r_out_valid || o_result.ready;
    assign w_s1_adv      = r_s1_valid && (!w_s1_is_read || w_out_free);
    assign i_item.ready  = !r_s1_valid || w_s1_adv;

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_s1.func            <= i_item.func;
            r_s1.sample_valid    <= i_item.sample_valid;
            r_s1.gun_x           <= i_item.gun_x;
            r_s1.gun_y           <= i_item.gun_y;
            r_s1.trigger         <= i_item.trigger;
            r_s1.write_bit       <= i_item.write_bit;
            r_s1.pixel_cycle     <= i_item.pixel_cycle;
            r_s1.aim_pixel_color <= i_item.aim_pixel_color;
        end
    end

    // ------------------------------------------------------------------
    // Light test on the held aim
    // ------------------------------------------------------------------
    lgp_light_detect #(
        .POS_W (POS_W)
    ) u_light (
        .i_aim_pos      (r_aim_pos),
        .i_aim_valid    (r_aim_valid),
        .i_pixel_cycle  (r_s1.pixel_cycle),
        .i_color        (r_s1.aim_pixel_color),
        .i_decay_window (r_decay_window),
        .o_light        (w_light)
    );

    assign w_on_screen = (BOUND_W'(r_s1.gun_x) < BOUND_W'(SCREEN_WIDTH)) &&
                         (BOUND_W'(r_s1.gun_y) < BOUND_W'(SCREEN_HEIGHT));

    // ------------------------------------------------------------------
    // Next state and read data
    // ------------------------------------------------------------------
    always_comb begin
        n_aim_pos      = r_aim_pos;
        n_aim_valid    = r_aim_valid;
        n_trigger_held = r_trigger_held;
        n_shift_en     = r_shift_en;
        n_serial_word  = r_serial_word;
        n_out_data     = '0;

        unique case (r_s1.func)
            FUNC_FRAME: begin
                // Drop the old aim; latch trigger even when aim is off screen
                n_aim_pos      = '0;
                n_aim_valid    = 1'b0;
                n_trigger_held = r_s1.sample_valid && r_s1.trigger;
                if (r_s1.sample_valid && w_on_screen) begin
                    n_aim_pos   = POS_W'(int'(r_s1.gun_y) * SCREEN_WIDTH +
                                         int'(r_s1.gun_x));
                    n_aim_valid = 1'b1;
                end
            end
            FUNC_READ: begin
                if (!r_serial_mode) begin
                    n_out_data = (r_trigger_held ? RD_TRIGGER : '0) |
                                 (w_light ? '0 : RD_NO_LIGHT);
                end else begin
                    // Return bit 0, then advance the status word when shifting is enabled
                    n_out_data    = DATA_W'(r_serial_word[0]);
                    n_serial_word = r_shift_en ? (r_serial_word >> 1) : r_serial_word;
                end
            end
            FUNC_WRITE: begin
                if (r_serial_mode) begin
                    n_shift_en    = !r_s1.write_bit;
                    n_serial_word = SW_FIXED |
                                    (r_trigger_held ? SW_TRIGGER : '0) |
                                    (w_light ? SW_LIGHT : '0);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aim_pos      <= '0;
            r_aim_valid    <= 1'b0;
            r_trigger_held <= 1'b0;
            r_shift_en     <= 1'b1;
            r_serial_word  <= SERIAL_WORD_RESET;
        end else if (w_s1_adv) begin
            r_aim_pos      <= n_aim_pos;
            r_aim_valid    <= n_aim_valid;
            r_trigger_held <= n_trigger_held;
            r_shift_en     <= n_shift_en;
            r_serial_word  <= n_serial_word;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv && w_s1_is_read) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_s1_is_read) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.read_data = r_out_data;

`ifndef SYNTHESIS
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1.func == FUNC_READ))
        else $error("result appeared without a read item");

    a_read_data_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data & ~(RD_TRIGGER | RD_NO_LIGHT | 8'h01)) == '0))
        else $error("read data carries undefined bits");

    a_aim_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_aim_valid |-> (r_aim_pos <= POS_MAX))
        else $error("aim position beyond screen");

    a_frame_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && r_s1.func == FUNC_FRAME && !r_s1.sample_valid)
            |=> (!r_aim_valid && !r_trigger_held))
        else $error("frame without sample kept aim or trigger");

    a_stalled_read_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1)))
        else $error("stalled item lost or changed");
`endif

endmodule
`default_nettype wire

@@ verif/light_gun_port_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// light_gun_port_tb
// Self-checking bench of the light-gun port: a queue-fed driver offers frame,
// read and write items, a clocked monitor predicts every read from its own
// model of aim, trigger, light test and serial word, and checks each result.
// ----------------------------------------------------------------------------
module light_gun_port_tb;

    import lgp_pkg::*;

    localparam int SCR_W       = SCREEN_WIDTH_DEF;
    localparam int SCR_H       = SCREEN_HEIGHT_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    // func code 3 has no meaning; the block must drop it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Brightness per palette index, 0x40 and up counts as lit
    localparam logic [7:0] LUM_TABLE [0:63] = '{
        8'h66, 8'h1C, 8'h1F, 8'h2A, 8'h31, 8'h2D, 8'h27, 8'h26,
        8'h29, 8'h2E, 8'h34, 8'h32, 8'h30, 8'h00, 8'h00, 8'h00,
        8'hB9, 8'h52, 8'h52, 8'h51, 8'h53, 8'h4F, 8'h54, 8'h59,
        8'h5E, 8'h5A, 8'h5A, 8'h5E, 8'h5D, 8'h00, 8'h00, 8'h00,
        8'hFF, 8'hA4, 8'hA0, 8'hA2, 8'hA2, 8'h9D, 8'hA0, 8'hA6,
        8'hA9, 8'hA8, 8'hA6, 8'hA6, 8'hAB, 8'h60, 8'h00, 8'h00,
        8'hFF, 8'hD8, 8'hD5, 8'hD1, 8'hCE, 8'hCE, 8'hCF, 8'hD5,
        8'hDD, 8'hD5, 8'hD1, 8'hD0, 8'hD6, 8'hBD, 8'h00, 8'h00
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    lgp_item_if   item_ch ();
    lgp_result_if res_ch ();
    lgp_cfg_if    cfg_ch ();

    light_gun_port #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_item             pending_items [$];   // items still to be offered
    logic [DATA_W-1:0] expected_reads [$];  // read data still to come back
    int                fail_count = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    bit                item_fired = 1'b0;   // item taken at the last rising edge
    bit                hold_req = 1'b0;     // ask the receiver for a long hold-off
    int                cycle_count = 0;

    // Predicted state of the port and its registers
    logic               cfg_serial;
    logic [CYCLE_W-1:0] cfg_decay;
    logic [15:0]        aim_pos;
    logic               aim_ok;
    logic               trig_held;
    logic               shift_on;
    logic [DATA_W-1:0]  status_word;

    // Generator's own view of the last aim point, used to steer pixel cycles
    int gen_aim    = 0;
    bit gen_aim_ok = 1'b0;

    // ------------------------------------------------------------------------
    // Port model
    // ------------------------------------------------------------------------

    // Light is seen only when the aim pixel was drawn within the decay window
    // ending at the current pixel cycle; no wrap below the start of the frame.
    function automatic bit pixel_lit(input logic [CYCLE_W-1:0] cyc,
                                     input logic [COLOR_W-1:0] color);
        int age;
        if (!aim_ok)
            return 1'b0;
        age = int'(cyc) - int'(aim_pos);
        if (age <= 0)
            return 1'b0;
        if (age > int'(cfg_decay))
            return 1'b0;
        return LUM_TABLE[color] >= 8'h40;
    endfunction

    // Advance the model by one accepted item; queue the read data it yields.
    function automatic void predict_access(input t_item it);
        int                pos;
        logic [DATA_W-1:0] rd;
        case (it.func)
            FUNC_FRAME: begin
                aim_ok    = 1'b0;
                aim_pos   = '0;
                trig_held = 1'b0;
                if (it.sample_valid) begin
                    // off-screen aim drops the aim but still latches trigger
                    trig_held = it.trigger;
                    if (int'(it.gun_y) < SCR_H && int'(it.gun_x) < SCR_W) begin
                        pos     = int'(it.gun_y) * SCR_W + int'(it.gun_x);
                        aim_pos = pos[15:0];
                        aim_ok  = 1'b1;
                    end
                end
            end
            FUNC_READ: begin
                if (!cfg_serial) begin
                    rd = (trig_held ? RD_TRIGGER : '0) |
                         (pixel_lit(it.pixel_cycle, it.aim_pixel_color) ? '0 : RD_NO_LIGHT);
                end else begin
                    rd          = {{(DATA_W-1){1'b0}}, status_word[0]};
                    status_word = shift_on ? (status_word >> 1) : status_word;
                end
                expected_reads.push_back(rd);
            end
            FUNC_WRITE: begin
                // a write in normal mode is dropped
                if (cfg_serial) begin
                    shift_on    = ~it.write_bit;
                    status_word = SW_FIXED | (trig_held ? SW_TRIGGER : '0) |
                        (pixel_lit(it.pixel_cycle, it.aim_pixel_color) ? SW_LIGHT : '0);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample all handshakes at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_port
        t_item             seen;
        logic [DATA_W-1:0] want;
        item_fired = item_ch.valid && item_ch.ready;
        if (!i_rst_n) begin
            // hold the model in its reset state
            cfg_serial  = 1'b0;
            cfg_decay   = DECAY_RESET;
            aim_pos     = '0;
            aim_ok      = 1'b0;
            trig_held   = 1'b0;
            shift_on    = 1'b1;
            status_word = SERIAL_WORD_RESET;
            item_fired  = 1'b0;
        end else begin
            // check the result first: it always belongs to an older item
            if (res_ch.valid && res_ch.ready) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: unexpected read_data, expected none, actual 0x%02h",
                             $time, res_ch.read_data);
                    fail_count++;
                end else begin
                    want = expected_reads.pop_front();
                    if (res_ch.read_data !== want) begin
                        $display("%0t: read_data mismatch, expected 0x%02h, actual 0x%02h",
                                 $time, want, res_ch.read_data);
                        fail_count++;
                    end
                end
            end
            if (item_fired) begin
                seen.func            = item_ch.func;
                seen.sample_valid    = item_ch.sample_valid;
                seen.gun_x           = item_ch.gun_x;
                seen.gun_y           = item_ch.gun_y;
                seen.trigger         = item_ch.trigger;
                seen.write_bit       = item_ch.write_bit;
                seen.pixel_cycle     = item_ch.pixel_cycle;
                seen.aim_pixel_color = item_ch.aim_pixel_color;
                predict_access(seen);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.addr == CFG_SERIAL_MODE)
                    cfg_serial = cfg_ch.data[0];
                else if (cfg_ch.addr == CFG_DECAY)
                    cfg_decay = cfg_ch.data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offer pending items at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_items
        t_item nxt;
        if (i_rst_n) begin
            // hold an item until it is taken, then advance or idle
            if (!item_ch.valid || item_fired) begin
                if (pending_items.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    item_ch.valid           <= 1'b1;
                    item_ch.func            <= nxt.func;
                    item_ch.sample_valid    <= nxt.sample_valid;
                    item_ch.gun_x           <= nxt.gun_x;
                    item_ch.gun_y           <= nxt.gun_y;
                    item_ch.trigger         <= nxt.trigger;
                    item_ch.write_bit       <= nxt.write_bit;
                    item_ch.pixel_cycle     <= nxt.pixel_cycle;
                    item_ch.aim_pixel_color <= nxt.aim_pixel_color;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_ready
        int hold_left;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** light_gun_port: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Write one configuration register; return once the write is taken.
    task automatic write_reg(input logic [CFG_A_W-1:0] idx,
                             input logic [CFG_D_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every item is taken and every read is back, then let
    // frame and write items still in the pipeline drain.
    task automatic settle();
        while (pending_items.size() != 0 || item_ch.valid || expected_reads.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void add_item(input logic [FUNC_W-1:0] fn, input int sv,
                                     input int gx, input int gy, input int trig,
                                     input int wb, input int cyc, input int color);
        t_item it;
        it.func            = fn;
        it.sample_valid    = 1'(sv);
        it.gun_x           = COORD_W'(gx);
        it.gun_y           = COORD_W'(gy);
        it.trigger         = 1'(trig);
        it.write_bit       = 1'(wb);
        it.pixel_cycle     = CYCLE_W'(cyc);
        it.aim_pixel_color = COLOR_W'(color);
        pending_items.push_back(it);
    endfunction

    // Random item: frames mostly on screen and accesses mostly near the aim pixel
    // so that the light window is hit, missed and met at its edges.
    function automatic t_item rand_item(input int decay);
        t_item it;
        int    pick;
        int    off;
        it.sample_valid    = 1'($urandom_range(0, 1));
        it.gun_x           = COORD_W'($urandom_range(0, 511));
        it.gun_y           = COORD_W'($urandom_range(0, 511));
        it.trigger         = 1'($urandom_range(0, 1));
        it.write_bit       = 1'($urandom_range(0, 1));
        it.pixel_cycle     = CYCLE_W'($urandom_range(0, 131071));
        it.aim_pixel_color = COLOR_W'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 15)
            it.func = FUNC_FRAME;
        else if (pick < 70)
            it.func = FUNC_READ;
        else if (pick < 95)
            it.func = FUNC_WRITE;
        else
            it.func = FUNC_UNUSED;

        if (it.func == FUNC_FRAME) begin
            it.sample_valid = ($urandom_range(0, 99) < 85);
            if ($urandom_range(0, 99) < 80) begin
                it.gun_x = COORD_W'($urandom_range(0, SCR_W - 1));
                it.gun_y = COORD_W'($urandom_range(0, SCR_H - 1));
            end
            gen_aim_ok = it.sample_valid && int'(it.gun_x) < SCR_W && int'(it.gun_y) < SCR_H;
            gen_aim    = int'(it.gun_y) * SCR_W + int'(it.gun_x);
        end else begin
            it.write_bit = ($urandom_range(0, 99) >= 70);
            pick = $urandom_range(0, 99);
            if (gen_aim_ok && pick < 65) begin
                if (pick < 10)
                    off = decay + $urandom_range(0, 1);   // window edge
                else if (pick < 15)
                    off = $urandom_range(0, 1);           // just drawn or not yet
                else
                    off = $urandom_range(0, decay + 1);
                it.pixel_cycle = CYCLE_W'(gen_aim + off);
            end else if (pick < 80) begin
                it.pixel_cycle = CYCLE_W'($urandom_range(0, 3));    // start of frame
            end
        end
        return it;
    endfunction

    // One random phase: idle mix, register setting and a batch of items.
    task automatic run_phase(input int s_idle, input int r_idle, input logic serial,
                             input int decay, input int count, input bit hold);
        settle();
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        write_reg(CFG_SERIAL_MODE, CFG_D_W'(serial));
        write_reg(CFG_DECAY, CFG_D_W'(decay));
        for (int n = 0; n < count; n++)
            pending_items.push_back(rand_item(decay));
        if (hold)
            hold_req = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n                 = 1'b0;
        item_ch.valid           = 1'b0;
        item_ch.func            = FUNC_FRAME;
        item_ch.sample_valid    = 1'b0;
        item_ch.gun_x           = '0;
        item_ch.gun_y           = '0;
        item_ch.trigger         = 1'b0;
        item_ch.write_bit       = 1'b0;
        item_ch.pixel_cycle     = '0;
        item_ch.aim_pixel_color = '0;
        res_ch.ready            = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.addr             = CFG_SERIAL_MODE;
        cfg_ch.data             = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Normal format, directed: reset read, light window edges, dark
        // colour, dropped write, missing sample, off-screen aim, far corner.
        send_idle_pct = 27;
        recv_idle_pct = 55;
        write_reg(CFG_SERIAL_MODE, CFG_D_W'(1'b0));
        write_reg(CFG_DECAY, DECAY_RESET);
        add_item(FUNC_READ,  0,   0,   0, 0, 0,      0, 6'h20);
        add_item(FUNC_FRAME, 1,  10,   0, 1, 0,      0, 6'h00);
        add_item(FUNC_READ,  0,   0,   0, 0, 0,     10, 6'h20);
        add_item(FUNC_READ,  0,   0,   0, 0, 0,     11, 6'h20);
        add_item(FUNC_READ,  0,   0,   0, 0, 0,    394, 6'h30);
        add_item(FUNC_READ,  0,   0,   0, 0, 0,    395, 6'h30);
        add_item(FUNC_READ,  0,   0,   0, 0, 0,     11, 6'h0D);
        add_item(FUNC_WRITE, 0,   0,   0, 0, 0,     11, 6'h20);
        add_item(FUNC_FRAME, 0,  10,   0, 1, 0,      0, 6'h00);
        add_item(FUNC_READ,  0,   0,   0, 0, 0,     11, 6'h20);
        add_item(FUNC_FRAME, 1, 256,   0, 1, 0,      0, 6'h00);
        add_item(FUNC_READ,  0,   0,   0, 0, 0,      1, 6'h20);
        add_item(FUNC_FRAME, 1, 255, 239, 0, 0,      0, 6'h00);
        add_item(FUNC_READ,  0,   0,   0, 0, 1, 131071, 6'h3F);
        settle();

        // Serial format, directed: reset word, load with shift, load with
        // shift held, unused code.
        write_reg(CFG_SERIAL_MODE, CFG_D_W'(1'b1));
        add_item(FUNC_FRAME,  1, 5, 0, 1, 0, 0, 6'h00);
        add_item(FUNC_READ,   0, 0, 0, 0, 0, 0, 6'h00);
        add_item(FUNC_WRITE,  0, 0, 0, 0, 0, 6, 6'h20);
        for (int n = 0; n < 6; n++)
            add_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 6'h00);
        add_item(FUNC_WRITE,  0, 0, 0, 0, 1, 5, 6'h20);
        add_item(FUNC_READ,   0, 0, 0, 0, 0, 0, 6'h00);
        add_item(FUNC_READ,   0, 0, 0, 0, 0, 0, 6'h00);
        add_item(FUNC_UNUSED, 1, 0, 0, 1, 0, 0, 6'h20);

        // Random phases; the last two run with no idling, the first of them
        // under a long receiver hold-off so the input side backs up.
        run_phase(27, 55, 1'b0, int'(DECAY_RESET),       117, 1'b0);
        run_phase(27, 55, 1'b1, $urandom_range(0, 131071), 117, 1'b0);
        run_phase(55, 27, 1'b0, 131071,                  117, 1'b0);
        run_phase(55, 27, 1'b1, 0,                       117, 1'b0);
        run_phase( 0,  0, 1'b0, $urandom_range(1, 2000), 117, 1'b1);
        run_phase( 0,  0, 1'b1, int'(DECAY_RESET),       117, 1'b0);

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_reads.size() == 0) begin
            $display("** light_gun_port: PASSED **");
        end else begin
            $display("%0t: %0d failures, %0d reads never returned",
                     $time, fail_count, expected_reads.size());
            $display("** light_gun_port: FAILED **");
        end
        $finish;
    end

endmodule
